/* hdl/mslrc_pkg.sv */
// Shared types and constants for the south-last mesh route candidate unit.
package mslrc_pkg;

  localparam int VcsPerVnet = 4;
  localparam int RouterW    = 8;
  localparam int ColW       = 5;
  localparam int VnetW      = 2;
  localparam int PortW      = 3;
  localparam int ChanW      = 4;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 8;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 8;
  localparam int DivBits    = 2;
  localparam int DivStages  = RouterW / DivBits;
  localparam int VcCntW     = (VcsPerVnet > 1) ? $clog2(VcsPerVnet) : 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOwnId   = 3'd0,
    CfgColumns = 3'd1,
    CfgEast    = 3'd2,
    CfgWest    = 3'd3,
    CfgNorth   = 3'd4,
    CfgSouth   = 3'd5
  } cfg_idx_e;

  // partial remainder and the dividend/quotient shift word
  typedef struct packed {
    logic [ColW-1:0]    rem;
    logic [RouterW-1:0] w;
  } div_t;

  typedef struct packed {
    div_t             dest;
    div_t             own;
    logic [VnetW-1:0] vnet;
    logic             north;
    logic             local_dst;
  } pipe_t;

  typedef struct packed {
    logic [PortW-1:0] port0;
    logic [PortW-1:0] port1;
    logic             two;
    logic [ChanW-1:0] base_chan;
    logic             local_dst;
  } dec_t;

endpackage

/* hdl/mslrc_div_stage.sv */
// One registered stage of the coordinate divider, DivBits quotient bits per stage.
module mslrc_div_stage import mslrc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ColW-1:0] cols_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  pipe_t           data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pipe_t           data_o
);

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;

  function automatic div_t div_step(div_t a, logic [ColW-1:0] d);
    logic [ColW:0] r;
    logic          qb;
    div_t          o;
    r  = {a.rem, a.w[RouterW-1]};
    qb = (r >= {1'b0, d});
    o.rem = qb ? ColW'(r - {1'b0, d}) : r[ColW-1:0];
    o.w   = {a.w[RouterW-2:0], qb};
    return o;
  endfunction

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < DivBits; s++) begin
      data_d.dest = div_step(data_d.dest, cols_i);
      data_d.own  = div_step(data_d.own, cols_i);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* hdl/mslrc_emitter.sv */
// Candidate sequencer: expands one routing decision into per-channel results.
module mslrc_emitter import mslrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dec_valid_i,
  output logic             dec_ready_o,
  input  dec_t             dec_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PortW-1:0] out_port_o,
  output logic [ChanW-1:0] out_chan_o,
  output logic             out_local_o,
  output logic             out_last_o
);

  logic              em_v_q;
  dec_t              em_q;
  logic              sel_q, sel_d;
  logic [VcCntW-1:0] j_q, j_d;
  logic              out_v_q;
  logic [PortW-1:0]  port_q;
  logic [ChanW-1:0]  chan_q;
  logic              local_q, last_q;
  logic              out_free, emit, j_end, cur_last, em_take;

  assign out_free = !out_v_q || out_ready_i;
  assign emit     = em_v_q && out_free;
  assign j_end    = (j_q == VcCntW'(VcsPerVnet - 1));
  assign cur_last = em_q.local_dst || (j_end && (sel_q || !em_q.two));
  assign em_take  = !em_v_q || (emit && cur_last);
  assign dec_ready_o = em_take;

  always_comb begin
    sel_d = sel_q;
    j_d   = j_q;
    if (em_take) begin
      sel_d = 1'b0;
      j_d   = '0;
    end else if (emit) begin
      if (j_end) begin
        sel_d = 1'b1;
        j_d   = '0;
      end else begin
        j_d = j_q + VcCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      sel_q   <= 1'b0;
      j_q     <= '0;
    end else begin
      if (em_take) begin
        em_v_q <= dec_valid_i;
      end
      if (out_free) begin
        out_v_q <= emit;
      end
      sel_q <= sel_d;
      j_q   <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_take && dec_valid_i) begin
      em_q <= dec_i;
    end
    if (emit) begin
      port_q  <= sel_q ? em_q.port1 : em_q.port0;
      chan_q  <= em_q.base_chan + ChanW'(j_q);
      local_q <= em_q.local_dst;
      last_q  <= cur_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_port_o  = port_q;
  assign out_chan_o  = chan_q;
  assign out_local_o = local_q;
  assign out_last_o  = last_q;

`ifndef SYNTHESIS
  a_sel_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_v_q && sel_q |-> em_q.two && !em_q.local_dst)
    else $error("second port selected for a single-port decision");

  a_hold_unfinished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_v_q && !(emit && cur_last) |=> em_v_q && $stable(em_q))
    else $error("decision dropped before its last candidate");

  a_local_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && local_q |-> last_q && port_q == '0 && chan_q == '0)
    else $error("local result is not a single zeroed last result");

  a_counter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !em_v_q |-> j_q == '0 && !sel_q)
    else $error("candidate counter not cleared while idle");
`endif

endmodule

/* hdl/mesh_south_last_route_candidates.sv */
// Top level: south-last turn model route candidate unit for a 2D mesh router.
// Pipeline: 7 register stages: 4 divider stages, decision stage, sequencer and
// output register.
// Output: VcsPerVnet results per chosen port, one result for a local destination;
// the output sequencer takes a new decision only as the last result is sent.
// Reset (async, active low) clears all valid bits and loads the register defaults.
module mesh_south_last_route_candidates import mslrc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // [7:0] destination id, [9:8] virtual_net
  input  logic                s_axis_tuser_i,  // [0] from_north
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // [2:0] out_port, [6:3] out_channel
  output logic                m_axis_tuser_o,  // [0] is_local
  output logic                m_axis_tlast_o   // last_candidate
);

  logic [RouterW-1:0] own_id_q;
  logic [ColW-1:0]    cols_q;
  logic [PortW-1:0]   east_q, west_q, north_q, south_q;
  logic [ColW-1:0]    cols_eff;

  assign cfg_ready_o = 1'b1;
  assign cols_eff    = (cols_q == '0) ? ColW'(1) : cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
      cols_q   <= ColW'(4);
      east_q   <= PortW'(1);
      west_q   <= PortW'(2);
      north_q  <= PortW'(3);
      south_q  <= PortW'(4);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOwnId:   own_id_q <= cfg_data_i;
        CfgColumns: cols_q   <= cfg_data_i[ColW-1:0];
        CfgEast:    east_q   <= cfg_data_i[PortW-1:0];
        CfgWest:    west_q   <= cfg_data_i[PortW-1:0];
        CfgNorth:   north_q  <= cfg_data_i[PortW-1:0];
        CfgSouth:   south_q  <= cfg_data_i[PortW-1:0];
        default: ;
      endcase
    end
  end

  // divider pipeline: x = id mod cols, y = id div cols for both ids
  pipe_t st_data [DivStages+1];
  logic  st_valid [DivStages+1];
  logic  st_ready [DivStages+1];

  always_comb begin
    st_data[0].dest.rem  = '0;
    st_data[0].dest.w    = s_axis_tdata_i[RouterW-1:0];
    st_data[0].own.rem   = '0;
    st_data[0].own.w     = own_id_q;
    st_data[0].vnet      = s_axis_tdata_i[RouterW+VnetW-1:RouterW];
    st_data[0].north     = s_axis_tuser_i;
    st_data[0].local_dst = (s_axis_tdata_i[RouterW-1:0] == own_id_q);
  end
  assign st_valid[0]     = s_axis_tvalid_i;
  assign s_axis_tready_o = st_ready[0];

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    mslrc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cols_i  (cols_eff),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  // decision stage
  pipe_t p;
  logic  dec_v_q;
  dec_t  dec_q, dec_d;
  logic  em_ready;
  logic  x_left, y_left, y_up;

  assign p      = st_data[DivStages];
  assign x_left = (p.dest.rem != p.own.rem);
  assign y_left = (p.dest.w != p.own.w);
  assign y_up   = (p.dest.w > p.own.w);

  always_comb begin
    dec_d.port0     = south_q;
    dec_d.port1     = north_q;
    dec_d.two       = 1'b0;
    dec_d.base_chan = ChanW'(p.vnet * VcsPerVnet);
    dec_d.local_dst = p.local_dst;
    if (p.local_dst) begin
      dec_d.port0     = '0;
      dec_d.base_chan = '0;
    end else if (!p.north) begin
      if (x_left) begin
        dec_d.port0 = (p.dest.rem > p.own.rem) ? east_q : west_q;
        dec_d.two   = y_left && y_up;
      end else begin
        dec_d.port0 = y_up ? north_q : south_q;
      end
    end
  end

  assign st_ready[DivStages] = !dec_v_q || em_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_v_q <= 1'b0;
    end else if (st_ready[DivStages]) begin
      dec_v_q <= st_valid[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready[DivStages] && st_valid[DivStages]) begin
      dec_q <= dec_d;
    end
  end

  logic [PortW-1:0] out_port;
  logic [ChanW-1:0] out_chan;

  mslrc_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (dec_v_q),
    .dec_ready_o (em_ready),
    .dec_i       (dec_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_port_o  (out_port),
    .out_chan_o  (out_chan),
    .out_local_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutDataW-PortW-ChanW){1'b0}}, out_chan, out_port};

endmodule
